### src/posting_list_next_geq_assert.svh
// Assertion macros for the posting list search block.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef POSTING_LIST_NEXT_GEQ_ASSERT_SVH
`define POSTING_LIST_NEXT_GEQ_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define PLNG_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define PLNG_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/plng_pkg.sv
// Shared types and constants for the posting list search block.
// No dependencies; used by plng_ctrl, plng_dpath and posting_list_next_geq.
`default_nettype none

package plng_pkg;

   // Default geometry
   localparam int BLOCK_SIZE_DEF = 128;
   localparam int MAX_BLOCKS_DEF = 64;
   localparam int ID_WIDTH_DEF   = 32;

   // Fixed field widths
   localparam int FUNC_W     = 2;
   localparam int POSITION_W = 13;
   localparam int DOC_ID_W   = 32;
   localparam int FREQ_W     = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;
   localparam int BCOUNT_W   = 7;
   localparam int LFILL_W    = 8;

   // Function codes
   localparam logic [FUNC_W-1:0] FUNC_LOAD_POST = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_LOAD_END  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_QUERY     = 2'd2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LAST_FILL   = 2'd1;

   // Register reset values
   localparam logic [BCOUNT_W-1:0] BCOUNT_RESET = 7'd1;
   localparam logic [LFILL_W-1:0]  LFILL_RESET  = 8'd128;

   typedef struct packed {
      logic [FUNC_W-1:0]     func;
      logic [POSITION_W-1:0] position;
      logic [DOC_ID_W-1:0]   doc_id;
      logic [FREQ_W-1:0]     freq_in;
   } req_type;

   typedef struct packed {
      logic [DOC_ID_W-1:0] next_doc;
      logic                found;
      logic                exact;
      logic [FREQ_W-1:0]   freq_out;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_O_RD,
      ST_O_CMP,
      ST_I_RD,
      ST_I_CMP,
      ST_EMIT
   } state_type;

   // Outcome of one search step against the probed entry
   typedef enum logic [1:0] {
      STEP_HIT,
      STEP_RIGHT,
      STEP_STOP,
      STEP_LEFT
   } step_type;

   typedef struct packed {
      logic accept;
      logic o_read;
      logic o_step;
      logic i_read;
      logic i_step;
      logic miss;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic     o_empty;
      logic     i_empty;
      step_type step;
      logic     out_free;
   } status_type;

endpackage

`default_nettype wire

### src/plng_ctrl.sv
// Sequencer for the two nested binary searches of the posting list block.
// Depends on plng_pkg and posting_list_next_geq_assert.svh.
`default_nettype none

`include "posting_list_next_geq_assert.svh"

module plng_ctrl (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic [plng_pkg::FUNC_W-1:0]    req_func,
   output logic                           req_stall,
   input  plng_pkg::status_type           status,
   output plng_pkg::cmd_type              cmd
);

   plng_pkg::state_type state_ff;
   plng_pkg::state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= plng_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = (state_ff != plng_pkg::ST_IDLE);
      case (state_ff)
         plng_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (req_func == plng_pkg::FUNC_QUERY) begin
                  state_in = plng_pkg::ST_O_RD;
               end
            end
         end
         plng_pkg::ST_O_RD: begin
            if (status.o_empty) begin
               cmd.miss = 1'b1;
               state_in = plng_pkg::ST_EMIT;
            end else begin
               cmd.o_read = 1'b1;
               state_in   = plng_pkg::ST_O_CMP;
            end
         end
         plng_pkg::ST_O_CMP: begin
            cmd.o_step = 1'b1;
            case (status.step)
               plng_pkg::STEP_HIT:  state_in = plng_pkg::ST_EMIT;
               plng_pkg::STEP_STOP: state_in = plng_pkg::ST_I_RD;
               default:             state_in = plng_pkg::ST_O_RD;
            endcase
         end
         plng_pkg::ST_I_RD: begin
            if (status.i_empty) begin
               cmd.miss = 1'b1;
               state_in = plng_pkg::ST_EMIT;
            end else begin
               cmd.i_read = 1'b1;
               state_in   = plng_pkg::ST_I_CMP;
            end
         end
         plng_pkg::ST_I_CMP: begin
            cmd.i_step = 1'b1;
            case (status.step)
               plng_pkg::STEP_HIT:  state_in = plng_pkg::ST_EMIT;
               plng_pkg::STEP_STOP: state_in = plng_pkg::ST_EMIT;
               default:             state_in = plng_pkg::ST_I_RD;
            endcase
         end
         plng_pkg::ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = plng_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = plng_pkg::ST_IDLE;
         end
      endcase
   end

   // Checks on the search sequence
   `PLNG_ASSERT_NXT(a_query_starts, clock, reset,
      cmd.accept && (req_func == plng_pkg::FUNC_QUERY), state_ff == plng_pkg::ST_O_RD,
      "query transaction did not start the block search")
   `PLNG_ASSERT_IMP(a_ocmp_after_read, clock, reset,
      state_ff == plng_pkg::ST_O_CMP, $past(state_ff) == plng_pkg::ST_O_RD,
      "block compare without a block read")
   `PLNG_ASSERT_IMP(a_icmp_after_read, clock, reset,
      state_ff == plng_pkg::ST_I_CMP, $past(state_ff) == plng_pkg::ST_I_RD,
      "entry compare without an entry read")
   `PLNG_ASSERT_IMP(a_inner_entry, clock, reset,
      state_ff == plng_pkg::ST_I_RD,
      ($past(state_ff) == plng_pkg::ST_O_CMP) || ($past(state_ff) == plng_pkg::ST_I_CMP),
      "entry search entered from a wrong state")
   `PLNG_ASSERT_NXT(a_emit_to_idle, clock, reset,
      cmd.emit, state_ff == plng_pkg::ST_IDLE,
      "result handoff did not return to idle")

endmodule

`default_nettype wire

### src/plng_dpath.sv
// Datapath of the posting list block: stores, search bounds, compare, result.
// Depends on plng_pkg; driven by plng_ctrl through cmd_type and status_type.
`default_nettype none

module plng_dpath #(
   parameter int BLOCK_SIZE = plng_pkg::BLOCK_SIZE_DEF,
   parameter int MAX_BLOCKS = plng_pkg::MAX_BLOCKS_DEF,
   parameter int ID_WIDTH   = plng_pkg::ID_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  plng_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output plng_pkg::rsp_type                 rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [plng_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [plng_pkg::CSR_DATA_W-1:0]   csr_data,
   input  plng_pkg::cmd_type                 cmd,
   output plng_pkg::status_type              status
);

   localparam int Postings = BLOCK_SIZE * MAX_BLOCKS;
   localparam int DocAw    = $clog2(Postings);
   localparam int BlkAw    = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int BlkW     = $clog2(MAX_BLOCKS + 1);
   localparam int PosW     = $clog2(BLOCK_SIZE + 1);
   localparam int BaseW    = DocAw + 1;
   localparam logic [ID_WIDTH-1:0] IdOnes = '1;

   // Stores
   logic [ID_WIDTH-1:0]            be_mem   [MAX_BLOCKS];
   logic [ID_WIDTH-1:0]            doc_mem  [Postings];
   logic [plng_pkg::FREQ_W-1:0]    freq_mem [Postings];

   // Configuration
   logic [plng_pkg::BCOUNT_W-1:0]  bcount_ff;
   logic [plng_pkg::LFILL_W-1:0]   lfill_ff;

   // Search state
   logic [ID_WIDTH-1:0]            target_ff;
   logic [BlkW-1:0]                l_ff, rp_ff, m_ff;
   logic [PosW-1:0]                il_ff, irp_ff, k_ff;
   logic [DocAw-1:0]               base_ff;
   logic                           sel_inner_ff;
   logic [ID_WIDTH-1:0]            be_a_ff, be_b_ff, doc_a_ff, doc_b_ff;
   logic [plng_pkg::FREQ_W-1:0]    freq_ff;
   plng_pkg::rsp_type              res_ff;
   plng_pkg::rsp_type              rsp_ff;
   logic                           rsp_valid_ff;

   // Combinational helpers
   logic [63:0]                    id_wide;
   logic [ID_WIDTH-1:0]            id_in;
   logic [31:0]                    pos_wide;
   logic [BlkW-1:0]                nb;
   logic [PosW-1:0]                fill;
   logic [BlkW-1:0]                m_cur;
   logic [PosW-1:0]                k_cur;
   logic [BlkAw-1:0]               be_idx_a, be_idx_b;
   logic [PosW-1:0]                last_off;
   logic [DocAw-1:0]               doc_addr_a, doc_addr_b, freq_addr;
   logic [ID_WIDTH-1:0]            cur, prev;
   logic                           first;
   plng_pkg::step_type             step;
   plng_pkg::rsp_type              hit_res, miss_res, stop_res;
   logic [63:0]                    target_wide, cur_wide, ones_wide;

   function automatic logic [DocAw-1:0] block_base(input logic [BlkW-1:0] blk);
      logic [BaseW-1:0] prod;
      prod = BaseW'(blk) * BaseW'(BLOCK_SIZE);
      return prod[DocAw-1:0];
   endfunction

   // Input id in store width, position widened to 32 bits
   assign id_wide  = 64'(req_data.doc_id);
   assign id_in    = id_wide[ID_WIDTH-1:0];
   assign pos_wide = 32'(req_data.position);

   // Saturate block count, clamp last block fill
   always_comb begin
      nb = (32'(bcount_ff) > MAX_BLOCKS) ? BlkW'(MAX_BLOCKS) : BlkW'(bcount_ff);
      if (lfill_ff == '0) begin
         fill = PosW'(1);
      end else if (32'(lfill_ff) > BLOCK_SIZE) begin
         fill = PosW'(BLOCK_SIZE);
      end else begin
         fill = PosW'(lfill_ff);
      end
   end

   // Probe points and read addresses
   always_comb begin
      m_cur      = l_ff + ((rp_ff - l_ff - 1'b1) >> 1);
      k_cur      = il_ff + ((irp_ff - il_ff - 1'b1) >> 1);
      be_idx_a   = m_cur[BlkAw-1:0];
      be_idx_b   = be_idx_a - 1'b1;
      last_off   = (m_cur == nb - 1'b1) ? fill - 1'b1 : PosW'(BLOCK_SIZE - 1);
      doc_addr_a = base_ff + DocAw'(k_cur);
      doc_addr_b = doc_addr_a - 1'b1;
      freq_addr  = cmd.o_read ? block_base(m_cur) + DocAw'(last_off) : doc_addr_a;
   end

   // Compare the probed entry with the target
   always_comb begin
      cur   = sel_inner_ff ? doc_a_ff : be_a_ff;
      prev  = sel_inner_ff ? doc_b_ff : be_b_ff;
      first = sel_inner_ff ? (k_ff == '0) : (m_ff == '0);
      if (target_ff == cur) begin
         step = plng_pkg::STEP_HIT;
      end else if (target_ff > cur) begin
         step = plng_pkg::STEP_RIGHT;
      end else if (first || (target_ff > prev)) begin
         step = plng_pkg::STEP_STOP;
      end else begin
         step = plng_pkg::STEP_LEFT;
      end
   end

   // Candidate results
   always_comb begin
      target_wide       = 64'(target_ff);
      cur_wide          = 64'(cur);
      ones_wide         = 64'(IdOnes);
      hit_res.next_doc  = target_wide[31:0];
      hit_res.found     = 1'b1;
      hit_res.exact     = 1'b1;
      hit_res.freq_out  = freq_ff;
      stop_res.next_doc = cur_wide[31:0];
      stop_res.found    = 1'b1;
      stop_res.exact    = 1'b0;
      stop_res.freq_out = '0;
      miss_res.next_doc = ones_wide[31:0];
      miss_res.found    = 1'b0;
      miss_res.exact    = 1'b0;
      miss_res.freq_out = '0;
   end

   // Stores: one write port, registered reads
   always_ff @(posedge clock) begin
      if (cmd.accept && (req_data.func == plng_pkg::FUNC_LOAD_END) &&
          (pos_wide < 32'(MAX_BLOCKS))) begin
         be_mem[pos_wide[BlkAw-1:0]] <= id_in;
      end
      if (cmd.o_read) begin
         be_a_ff <= be_mem[be_idx_a];
         be_b_ff <= be_mem[be_idx_b];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept && (req_data.func == plng_pkg::FUNC_LOAD_POST) &&
          (pos_wide < 32'(Postings))) begin
         doc_mem[pos_wide[DocAw-1:0]] <= id_in;
      end
      if (cmd.i_read) begin
         doc_a_ff <= doc_mem[doc_addr_a];
         doc_b_ff <= doc_mem[doc_addr_b];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept && (req_data.func == plng_pkg::FUNC_LOAD_POST) &&
          (pos_wide < 32'(Postings))) begin
         freq_mem[pos_wide[DocAw-1:0]] <= req_data.freq_in;
      end
      if (cmd.o_read || cmd.i_read) begin
         freq_ff <= freq_mem[freq_addr];
      end
   end

   // Configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         bcount_ff <= plng_pkg::BCOUNT_RESET;
         lfill_ff  <= plng_pkg::LFILL_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            plng_pkg::CSR_BLOCK_COUNT: bcount_ff <= csr_data[plng_pkg::BCOUNT_W-1:0];
            plng_pkg::CSR_LAST_FILL:   lfill_ff  <= csr_data[plng_pkg::LFILL_W-1:0];
            default: ;
         endcase
      end
   end

   // Search bounds: narrow the block range, then the entry range
   always_ff @(posedge clock) begin
      if (cmd.accept && (req_data.func == plng_pkg::FUNC_QUERY)) begin
         target_ff <= id_in;
         l_ff      <= '0;
         rp_ff     <= nb;
      end
      if (cmd.o_read) begin
         m_ff         <= m_cur;
         sel_inner_ff <= 1'b0;
      end
      if (cmd.i_read) begin
         k_ff         <= k_cur;
         sel_inner_ff <= 1'b1;
      end
      if (cmd.o_step) begin
         case (step)
            plng_pkg::STEP_HIT:   res_ff <= hit_res;
            plng_pkg::STEP_RIGHT: l_ff   <= m_ff + 1'b1;
            plng_pkg::STEP_STOP: begin
               base_ff <= block_base(m_ff);
               il_ff   <= '0;
               irp_ff  <= (m_ff == nb - 1'b1) ? fill : PosW'(BLOCK_SIZE);
            end
            default:              rp_ff  <= m_ff;
         endcase
      end
      if (cmd.i_step) begin
         case (step)
            plng_pkg::STEP_HIT:   res_ff <= hit_res;
            plng_pkg::STEP_RIGHT: il_ff  <= k_ff + 1'b1;
            plng_pkg::STEP_STOP:  res_ff <= stop_res;
            default:              irp_ff <= k_ff;
         endcase
      end
      if (cmd.miss) begin
         res_ff <= miss_res;
      end
   end

   // Output register: load on handoff, drop when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_ff <= res_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Status to the sequencer
   always_comb begin
      status.o_empty  = !(l_ff < rp_ff);
      status.i_empty  = !(il_ff < irp_ff);
      status.step     = step;
      status.out_free = !rsp_valid_ff || !rsp_stall;
   end

endmodule

`default_nettype wire

### src/posting_list_next_geq.sv
// Top level of the blocked posting list next-greater-or-equal search.
// Depends on plng_pkg, plng_ctrl and plng_dpath.
//
//   channel  direction  handshake          payload
//   req      in         req_valid/stall    plng_pkg::req_type
//   rsp      out        rsp_valid/stall    plng_pkg::rsp_type
//   csr      in         csr_valid/ready    csr_index, csr_data
//
// A load transaction gives no result.
// A query is accepted, then runs a block search and an entry search and hands off its
// result; a search that runs out of range ends in a miss. Each search step is one
// registered store read and one compare.
// Reset is synchronous: it clears the sequencer and the output valid and sets the registers to their reset values.
// While a result waits on rsp_stall, loads and a new query are still accepted;
// the query then holds in its final state until the output register frees.
`default_nettype none

module posting_list_next_geq #(
   parameter int BLOCK_SIZE = plng_pkg::BLOCK_SIZE_DEF,
   parameter int MAX_BLOCKS = plng_pkg::MAX_BLOCKS_DEF,
   parameter int ID_WIDTH   = plng_pkg::ID_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  plng_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output plng_pkg::rsp_type                 rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [plng_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [plng_pkg::CSR_DATA_W-1:0]   csr_data
);

   plng_pkg::cmd_type    cmd;
   plng_pkg::status_type status;

   plng_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_data.func),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   plng_dpath #(
      .BLOCK_SIZE (BLOCK_SIZE),
      .MAX_BLOCKS (MAX_BLOCKS),
      .ID_WIDTH   (ID_WIDTH)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .status    (status)
   );

endmodule

`default_nettype wire
